// ----- rtl/core/rsq_pkg.sv -----
// shared types, codes and constants of the reliable send queue core
// no dependencies
package rsq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CMD_DEPTH       = 2;     // power of two
    localparam int CMD_PW          = $clog2(CMD_DEPTH);

    localparam logic [14:0] SEQ_LIMIT    = 15'h7FFF;
    localparam logic [16:0] TIMER_MAX    = 17'h1FFFF;
    localparam logic [15:0] RESEND_RESET = 16'd100;

    typedef enum logic [2:0] {
        FN_QUEUE  = 3'd0,
        FN_TICK   = 3'd1,
        FN_ACK    = 3'd2,
        FN_CLEAR  = 3'd3,
        FN_DIRECT = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        KD_SEND   = 2'd0,
        KD_RESEND = 2'd1,
        KD_DROP   = 2'd2
    } t_kind;

    typedef struct packed {
        t_func       func;
        logic        guaranteed;
        logic [15:0] handle;
        logic [15:0] ticks;
        logic [14:0] ack;
    } t_cmd;

    // sequence index counts 1..32766 and wraps to 1
    function automatic logic [14:0] take_index(input logic [14:0] cur);
        logic [14:0] nxt;
        nxt = cur + 15'd1;
        if (nxt == SEQ_LIMIT || nxt == 15'd0) begin
            nxt = 15'd1;
        end
        return nxt;
    endfunction

endpackage

// ----- rtl/core/rsq_front.sv -----
// front end: accepts input words, decodes the operation, queues commands
// depends on rsq_pkg
module rsq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_func,
    input  logic              i_guaranteed,
    input  logic [15:0]       i_handle,
    input  logic [15:0]       i_ticks,
    input  logic [14:0]       i_ack,
    output logic              o_cmd_valid,
    output rsq_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    import rsq_pkg::*;

    t_cmd              r_buf [CMD_DEPTH];
    logic [CMD_PW-1:0] r_wp, n_wp;
    logic [CMD_PW-1:0] r_rp, n_rp;
    logic [CMD_PW:0]   r_cnt, n_cnt;
    logic              known;
    logic              push;
    logic              pop;
    t_cmd              cmd_in;

    assign o_ready     = (r_cnt != (CMD_PW+1)'(CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_buf[r_rp];

    // unused operation codes are taken and dropped here
    assign known = (i_func <= 3'(FN_DIRECT));
    assign push  = i_valid && o_ready && known;
    assign pop   = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cmd_in.func       = t_func'(i_func);
        cmd_in.guaranteed = i_guaranteed;
        cmd_in.handle     = i_handle;
        cmd_in.ticks      = i_ticks;
        cmd_in.ack        = i_ack;
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (CMD_PW+1)'(push) - (CMD_PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= cmd_in;
        end
    end

endmodule

// ----- rtl/core/rsq_back.sv -----
// back end: packet queue memory, pending packet, resend timer, result register
// depends on rsq_pkg
module rsq_back #(
    parameter int QUEUE_DEPTH = rsq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_cmd_valid,
    input  rsq_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output rsq_pkg::t_kind    o_kind,
    output logic [15:0]       o_header,
    output logic [15:0]       o_handle,
    output logic              o_last
);
    import rsq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;

    typedef struct packed {
        logic        flag;
        logic [14:0] seq;
        logic [15:0] handle;
    } t_entry;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} t_state;

    t_entry      mem [QUEUE_DEPTH];
    t_entry      r_rd;

    t_state      r_state, n_state;
    logic [15:0] r_interval;
    logic [14:0] r_next_idx, n_next_idx;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic        r_pend, n_pend;
    logic [14:0] r_pseq, n_pseq;
    logic [15:0] r_phnd, n_phnd;
    logic [16:0] r_timer, n_timer;
    logic        r_out_valid, n_out_valid;
    t_kind       r_kind, n_kind;
    logic [15:0] r_hdr, n_hdr;
    logic [15:0] r_hnd, n_hnd;
    logic        r_last, n_last;

    logic          out_free;
    logic          mem_we;
    t_entry        mem_wdata;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;
    logic [14:0]   idx_taken;
    logic [17:0]   timer_sum;
    logic [16:0]   timer_sat;
    logic          full;

    assign o_valid  = r_out_valid;
    assign o_kind   = r_kind;
    assign o_header = r_hdr;
    assign o_handle = r_hnd;
    assign o_last   = r_last;

    assign out_free  = !r_out_valid || i_ready;
    assign idx_taken = take_index(r_next_idx);
    assign full      = (r_count == CW'(QUEUE_DEPTH));
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                       AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);
    assign timer_sum = {1'b0, r_timer} + 18'(i_cmd.ticks);
    assign timer_sat = timer_sum[17] ? TIMER_MAX : timer_sum[16:0];

    always_comb begin
        mem_wdata.flag   = i_cmd.guaranteed;
        mem_wdata.seq    = idx_taken;
        mem_wdata.handle = i_cmd.handle;
    end

    always_comb begin
        n_state     = r_state;
        n_next_idx  = r_next_idx;
        n_head      = r_head;
        n_count     = r_count;
        n_pend      = r_pend;
        n_pseq      = r_pseq;
        n_phnd      = r_phnd;
        n_timer     = r_timer;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_hdr       = r_hdr;
        n_hnd       = r_hnd;
        n_last      = r_last;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.func)
                        FN_QUEUE: begin
                            if (full) begin
                                n_out_valid = 1'b1;
                                n_kind      = KD_DROP;
                                n_hdr       = '0;
                                n_hnd       = i_cmd.handle;
                                n_last      = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                n_next_idx = idx_taken;
                                n_count    = r_count + 1'b1;
                                if (r_pend) begin
                                    if (r_timer >= {1'b0, r_interval}) begin
                                        n_timer     = '0;
                                        n_out_valid = 1'b1;
                                        n_kind      = KD_RESEND;
                                        n_hdr       = {1'b1, r_pseq};
                                        n_hnd       = r_phnd;
                                        n_last      = 1'b1;
                                    end
                                end else begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        FN_TICK: begin
                            if (r_pend) begin
                                if (timer_sat >= {1'b0, r_interval}) begin
                                    n_timer     = '0;
                                    n_out_valid = 1'b1;
                                    n_kind      = KD_RESEND;
                                    n_hdr       = {1'b1, r_pseq};
                                    n_hnd       = r_phnd;
                                    n_last      = 1'b1;
                                end else begin
                                    n_timer = timer_sat;
                                end
                            end else if (r_count != '0) begin
                                n_state = S_READ;
                            end
                        end
                        FN_ACK: begin
                            if (r_pend && i_cmd.ack == r_pseq) begin
                                n_pend = 1'b0;
                            end
                        end
                        FN_CLEAR: begin
                            n_pend  = 1'b0;
                            n_head  = '0;
                            n_count = '0;
                        end
                        FN_DIRECT: begin
                            n_next_idx  = idx_taken;
                            n_out_valid = 1'b1;
                            n_kind      = KD_SEND;
                            n_hdr       = {1'b0, idx_taken};
                            n_hnd       = i_cmd.handle;
                            n_last      = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                // head entry lands in r_rd at this edge
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KD_SEND;
                    n_hdr       = {r_rd.flag, r_rd.seq};
                    n_hnd       = r_rd.handle;
                    n_head      = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count     = r_count - 1'b1;
                    if (r_rd.flag) begin
                        n_pend  = 1'b1;
                        n_pseq  = r_rd.seq;
                        n_phnd  = r_rd.handle;
                        n_timer = '0;
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_count == CW'(1)) begin
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_last  = 1'b0;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= RESEND_RESET;
            r_next_idx  <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_pseq      <= '0;
            r_phnd      <= '0;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            r_next_idx  <= n_next_idx;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_pseq      <= n_pseq;
            r_phnd      <= n_phnd;
            r_timer     <= n_timer;
            r_out_valid <= n_out_valid;
        end
        r_kind <= n_kind;
        r_hdr  <= n_hdr;
        r_hnd  <= n_hnd;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[tail] <= mem_wdata;
        end
        r_rd <= mem[r_head];
    end

endmodule

// ----- rtl/core/reliable_send_queue_arq_core.sv -----
// top level of the stop-and-wait send queue core
// depends on rsq_pkg, rsq_front, rsq_back
//
// usage: one command word per input beat (queue packet, tick, ack, clear
// queue, direct send), selected by s_axis_tuser. a queue packet, tick or direct
// send may produce results on the master side: sends, resends of the pending
// guaranteed packet, or a drop report when the packet queue is full.
// tlast marks the final result of one command word; commands that give no
// result (ack, clear, unknown codes, quiet ticks) show nothing on the output.
// the front decodes into a two-entry command queue, so input is taken
// while the back end works or the output stalls. a direct send, resend or
// drop report goes from the command queue into the result register; each
// flushed send is read from the packet queue into r_rd in S_READ and put in
// the result register in S_EMIT, one packet after the other, and the back
// end takes the next command only when the flush ends. a stalled receiver
// holds the result register and the back end waits; the command queue then
// fills and s_axis_tready falls. reset clears queue, pending packet, timer
// and index counter, and sets the resend interval to 100 ticks. i_cfg_we writes
// the interval; the user must write it only while idle, the block does not enforce it.
module reliable_send_queue_arq_core #(
    parameter int QUEUE_DEPTH = rsq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // payload_handle, elapsed_ticks, ack_index, pad
    input  logic [3:0]  s_axis_tuser,   // func, guaranteed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // header_word, out_handle
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);
    import rsq_pkg::*;

    logic        cmd_valid;
    t_cmd        cmd;
    logic        cmd_pop;
    t_kind       kind;
    logic [15:0] header;
    logic [15:0] handle;

    rsq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser[2:0]),
        .i_guaranteed (s_axis_tuser[3]),
        .i_handle     (s_axis_tdata[15:0]),
        .i_ticks      (s_axis_tdata[31:16]),
        .i_ack        (s_axis_tdata[46:32]),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    rsq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (kind),
        .o_header    (header),
        .o_handle    (handle),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {handle, header};
    assign m_axis_tuser = 2'(kind);

endmodule

// ----- tb/sv/rsq_arq_checker.sv -----
`timescale 1ns / 100ps
// checker of the reliable send queue core: watches both streams, predicts the result
// words of each accepted command word and compares them field by field
// depends on rsq_pkg
module rsq_arq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // payload_handle, elapsed_ticks, ack_index, pad
    input  logic [3:0]  s_axis_tuser,   // func, guaranteed
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // header_word, out_handle
    input  logic [1:0]  m_axis_tuser,   // kind
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_words_due,
    output logic        o_held_valid,
    output logic [14:0] o_held_seq
);
    import rsq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] header;
        logic [15:0] handle;
        logic        last;
    } t_result;

    t_result                  due_words[$];
    t_result                  item_words[$];

    logic [15:0]              interval;
    logic [14:0]              seq_ctr;
    logic [15:0]              fifo_handle [DEPTH];
    logic                     fifo_guar   [DEPTH];
    logic [14:0]              fifo_seq    [DEPTH];
    logic [$clog2(DEPTH)-1:0] fifo_head;
    logic [$clog2(DEPTH):0]   fifo_count;
    logic                     held_valid;
    logic [14:0]              held_seq;
    logic [15:0]              held_handle;
    logic [16:0]              resend_acc;
    int                       fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [14:0] next_seq(input logic [14:0] cur);
        if (cur >= SEQ_LIMIT - 15'd1) begin
            return 15'd1;
        end
        return cur + 15'd1;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic add_word(input t_kind kind, input logic [15:0] hdr, input logic [15:0] h);
        t_result w;
        w.kind   = kind;
        w.header = hdr;
        w.handle = h;
        w.last   = 1'b0;
        item_words.push_back(w);
    endtask

    task automatic serve_queue(input logic [15:0] ticks);
        logic [17:0]              sum;
        logic [$clog2(DEPTH)-1:0] slot;
        bit                       stop;
        stop = 1'b0;
        if (held_valid) begin
            sum = 18'(resend_acc) + 18'(ticks);
            if (sum > {1'b0, TIMER_MAX}) begin
                sum = {1'b0, TIMER_MAX};
            end
            if (sum[16:0] >= {1'b0, interval}) begin
                resend_acc = '0;
                add_word(KD_RESEND, {1'b1, held_seq}, held_handle);
            end else begin
                resend_acc = sum[16:0];
            end
        end else begin
            while (fifo_count != 0 && !stop) begin
                slot = fifo_head;
                fifo_head = fifo_head + 1'b1;
                fifo_count = fifo_count - 1'b1;
                if (!fifo_guar[slot]) begin
                    add_word(KD_SEND, {1'b0, fifo_seq[slot]}, fifo_handle[slot]);
                end else begin
                    held_valid  = 1'b1;
                    held_seq    = fifo_seq[slot];
                    held_handle = fifo_handle[slot];
                    resend_acc  = '0;
                    add_word(KD_SEND, {1'b1, fifo_seq[slot]}, fifo_handle[slot]);
                    stop = 1'b1;
                end
            end
        end
    endtask

    task automatic predict_sends(input logic [2:0] f, input logic g, input logic [15:0] h,
                                 input logic [15:0] ticks, input logic [14:0] ack);
        logic [$clog2(DEPTH)-1:0] slot;
        t_result                  w;
        item_words.delete();
        case (f)
            FN_QUEUE: begin
                if (fifo_count >= DEPTH) begin
                    add_word(KD_DROP, 16'd0, h);
                end else begin
                    slot = fifo_head + fifo_count[$clog2(DEPTH)-1:0];
                    seq_ctr = next_seq(seq_ctr);
                    fifo_seq[slot]    = seq_ctr;
                    fifo_guar[slot]   = g;
                    fifo_handle[slot] = h;
                    fifo_count = fifo_count + 1'b1;
                    serve_queue(16'd0);
                end
            end
            FN_TICK: begin
                serve_queue(ticks);
            end
            FN_ACK: begin
                if (held_valid && ack == held_seq) begin
                    held_valid = 1'b0;
                end
            end
            FN_CLEAR: begin
                held_valid = 1'b0;
                fifo_head  = '0;
                fifo_count = '0;
            end
            FN_DIRECT: begin
                seq_ctr = next_seq(seq_ctr);
                add_word(KD_SEND, {1'b0, seq_ctr}, h);
            end
            default: begin
            end
        endcase
        for (int i = 0; i < item_words.size(); i++) begin
            w = item_words[i];
            w.last = (i == item_words.size() - 1);
            due_words.push_back(w);
        end
    endtask

    task automatic check_word();
        t_result exp;
        if (due_words.size() == 0) begin
            report_mismatch($sformatf("result word with none expected: kind %0d hdr %h handle %h",
                                      m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]));
        end else begin
            exp = due_words.pop_front();
            if (m_axis_tuser !== exp.kind) begin
                report_mismatch($sformatf("kind %0d, expected %0d", m_axis_tuser, exp.kind));
            end
            if (m_axis_tdata[15:0] !== exp.header) begin
                report_mismatch($sformatf("header_word %h, expected %h",
                                          m_axis_tdata[15:0], exp.header));
            end
            if (m_axis_tdata[31:16] !== exp.handle) begin
                report_mismatch($sformatf("out_handle %h, expected %h",
                                          m_axis_tdata[31:16], exp.handle));
            end
            if (m_axis_tlast !== exp.last) begin
                report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, exp.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            interval    = RESEND_RESET;
            seq_ctr     = '0;
            fifo_head   = '0;
            fifo_count  = '0;
            held_valid  = 1'b0;
            held_seq    = '0;
            held_handle = '0;
            resend_acc  = '0;
            due_words.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_word();
            end
            if (i_cfg_we) begin
                interval = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sends(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[15:0],
                              s_axis_tdata[31:16], s_axis_tdata[46:32]);
            end
        end
        o_words_due  <= due_words.size();
        o_held_valid <= held_valid;
        o_held_seq   <= held_seq;
    end

endmodule

// ----- tb/sv/reliable_send_queue_arq_core_test.sv -----
`timescale 1ns / 100ps
// top of the reliable send queue core testbench: clock, reset, command stimulus,
// output backpressure and the verdict
// depends on rsq_pkg, rsq_arq_checker and reliable_send_queue_arq_core
module reliable_send_queue_arq_core_test;
    import rsq_pkg::*;

    localparam int RUN_LIMIT    = 1_500_000;
    localparam int PHASE_ITEMS  = 48;
    localparam int DRAIN_CYCLES = 16;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // payload_handle, elapsed_ticks, ack_index, pad
    logic [3:0]  s_axis_tuser  = '0;   // func, guaranteed
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // header_word, out_handle
    logic [1:0]  m_axis_tuser;         // kind
    logic        m_axis_tlast;

    int          fail_count;
    int          words_due;
    logic        held_valid;
    logic [14:0] held_seq;
    logic        calm = 1'b0;
    int          interval_now = int'(RESEND_RESET);
    int          cycles = 0;

    reliable_send_queue_arq_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rsq_arq_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_words_due   (words_due),
        .o_held_valid  (held_valid),
        .o_held_seq    (held_seq)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("** reliable_send_queue_arq_core: FAILED **");
            $finish;
        end
    end

    task automatic put_word(input logic [2:0] f, input logic g, input logic [15:0] h,
                            input logic [15:0] ticks, input logic [14:0] ack);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 16) begin
            gap = $urandom_range(5, 1);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ack, ticks, h};
        s_axis_tuser  <= {g, f};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        interval_now = int'(value);
    endtask

    task automatic random_word();
        int          roll;
        logic [2:0]  f;
        logic        g;
        logic [15:0] h;
        logic [15:0] ticks;
        logic [14:0] ack;
        roll  = $urandom_range(99);
        g     = 1'($urandom_range(1, 0));
        h     = 16'($urandom);
        ticks = 16'($urandom);
        ack   = 15'($urandom);
        if (roll < 45) begin
            f = FN_QUEUE;
            g = ($urandom_range(99) < 30);
        end else if (roll < 70) begin
            f = FN_TICK;
            case ($urandom_range(3))
                0: ticks = 16'd0;
                1: ticks = 16'hFFFF;
                2: ticks = 16'($urandom_range(interval_now, 0));
                default: begin
                end
            endcase
        end else if (roll < 85) begin
            f = FN_ACK;
            if (held_valid && $urandom_range(99) < 70) begin
                ack = held_seq;
            end
        end else if (roll < 89) begin
            f = FN_CLEAR;
        end else if (roll < 97) begin
            f = FN_DIRECT;
        end else begin
            f = 3'($urandom_range(7, 5));
        end
        put_word(f, g, h, ticks, ack);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, queue and resend flow, full queue, odd codes
        put_word(FN_DIRECT, 1'b0, 16'h0000, 16'h0000, 15'h0000);
        put_word(FN_DIRECT, 1'b1, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        put_word(FN_QUEUE,  1'b0, 16'h1234, 16'h0000, 15'h0000);
        put_word(FN_QUEUE,  1'b1, 16'hA5A5, 16'h0000, 15'h0000);
        put_word(FN_QUEUE,  1'b0, 16'h0001, 16'h0000, 15'h0000);
        put_word(FN_QUEUE,  1'b1, 16'h8000, 16'h0000, 15'h0000);
        put_word(FN_TICK,   1'b0, 16'h0000, 16'd99,   15'h0000);
        put_word(FN_TICK,   1'b0, 16'h0000, 16'd1,    15'h0000);
        put_word(FN_ACK,    1'b0, 16'h0000, 16'h0000, held_seq ^ 15'h0001);
        put_word(FN_ACK,    1'b0, 16'h0000, 16'h0000, held_seq);
        put_word(FN_TICK,   1'b0, 16'h0000, 16'h0000, 15'h0000);
        for (int i = 0; i <= QUEUE_DEPTH_DEF; i++) begin
            put_word(FN_QUEUE, 1'b0, 16'hF000 + 16'(i), 16'h0000, 15'h0000);
        end
        put_word(FN_TICK,   1'b0, 16'h0000, 16'hFFFF, 15'h0000);
        put_word(3'd5,      1'b1, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        put_word(3'd6,      1'b0, 16'h0000, 16'h0000, 15'h0000);
        put_word(3'd7,      1'b1, 16'h5A5A, 16'h0000, 15'h0000);
        put_word(FN_CLEAR,  1'b0, 16'h0000, 16'h0000, 15'h0000);
        put_word(FN_ACK,    1'b0, 16'h0000, 16'h0000, 15'h7FFF);
        put_word(FN_TICK,   1'b0, 16'h0000, 16'h0000, 15'h0000);

        write_interval(16'd1);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_word();
        end

        write_interval(16'hFFFF);
        calm = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_word();
        end
        calm = 1'b0;

        write_interval(16'd0);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_word();
            if (i == PHASE_ITEMS / 2) begin
                wait_drained();
            end
        end

        write_interval(16'($urandom_range(200, 2)));
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_word();
        end

        wait_drained();
        if (fail_count == 0 && words_due == 0) begin
            $display("** reliable_send_queue_arq_core: PASSED **");
        end else begin
            $display("** reliable_send_queue_arq_core: FAILED **");
        end
        $finish;
    end

endmodule
